@@ design/row_span_frustum_clip_top_defines.svh @@
// Assertion macros for the row span unit.
// Used by row_span_frustum_clip_top; expects clk and arst_n in scope.
`ifndef ROW_SPAN_FRUSTUM_CLIP_TOP_DEFINES_SVH
`define ROW_SPAN_FRUSTUM_CLIP_TOP_DEFINES_SVH

`define RSFC_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define RSFC_CHECK_IMP(lbl, ante, cons, msg) \
	`RSFC_CHECK(lbl, (ante) |-> (cons), msg)

`endif

@@ design/rsfc_pkg.sv @@
// Shared types and constants of the row span unit.
// No dependencies.
`default_nettype none
package rsfc_pkg;

	localparam int MAP_SIZE_DEF = 1024;
	localparam int DIV_STEPS = 27;
	localparam int SQRT_STEPS = 24;

	typedef enum logic [2:0] {
		REG_RIGHT_DX = 3'd0,
		REG_RIGHT_DY = 3'd1,
		REG_LEFT_DX  = 3'd2,
		REG_LEFT_DY  = 3'd3,
		REG_NEAR_OFS = 3'd4,
		REG_CENTER_C = 3'd5,
		REG_CENTER_R = 3'd6,
		REG_RADIUS   = 3'd7
	} rsfc_reg_t;

	typedef struct packed {
		logic signed [31:0] right_dx;
		logic signed [31:0] right_dy;
		logic signed [31:0] left_dx;
		logic signed [31:0] left_dy;
		logic signed [31:0] near_ofs;
		logic [9:0]         center_col;
		logic [9:0]         center_row;
		logic [7:0]         radius;
		logic [31:0]        abs_right_dx;
		logic [31:0]        abs_left_dx;
	} rsfc_cfg_t;

	typedef struct packed {
		logic        neg;
		logic        ovf;
		logic [32:0] rem;
		logic [26:0] quo;
		logic [10:0] low;
	} rsfc_div_t;

	typedef struct packed {
		logic        vld;
		logic        skip;
		logic [15:0] d2;
		logic [26:0] srem;
		logic [23:0] root;
		rsfc_div_t   dr;
		rsfc_div_t   dl;
	} rsfc_iter_t;

endpackage
`default_nettype wire

@@ design/rsfc_front.sv @@
// Front stages: row reach test, disk and plane products, divider setup.
// Depends on rsfc_pkg.
`default_nettype none
module rsfc_front #(
	parameter int MAP_SIZE = rsfc_pkg::MAP_SIZE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic               req_xfer,
	input  wire logic [9:0]         row_index,
	input  wire rsfc_pkg::rsfc_cfg_t cfg,
	output rsfc_pkg::rsfc_iter_t    it_s5
);
	import rsfc_pkg::*;

	localparam logic signed [13:0] MAP_MAX = 14'(MAP_SIZE - 1);

	logic              vld_s1;
	logic [9:0]        row_s1;
	logic              vld_s2, skip_s2;
	logic signed [8:0] dy_s2;
	logic              vld_s3, skip_s3;
	logic signed [17:0] d2_s3;
	logic signed [40:0] pr_s3, pl_s3;
	logic              vld_s4, skip_s4;
	logic [15:0]       d2_s4;
	logic signed [41:0] rhr_s4, rhl_s4;

	logic signed [13:0] y_lo, y_hi, row14, dy14;
	logic               reach;
	logic signed [17:0] dsq, rsq, d2;
	logic signed [40:0] prod_r, prod_l;
	logic signed [41:0] cext, rhs_r, rhs_l;
	logic               skip3;
	logic [41:0]        mag_r, mag_l;
	rsfc_iter_t         init;

	always_comb begin
		y_lo = $signed({4'b0, cfg.center_row}) - $signed({6'b0, cfg.radius});
		if (y_lo < 0) begin
			y_lo = '0;
		end
		y_hi = $signed({4'b0, cfg.center_row}) + $signed({6'b0, cfg.radius});
		if (y_hi > MAP_MAX) begin
			y_hi = MAP_MAX;
		end
		row14 = $signed({4'b0, row_s1});
		reach = (row14 >= y_lo) && (row14 <= y_hi);
		dy14  = row14 - $signed({4'b0, cfg.center_row});
	end

	always_comb begin
		rsq    = $signed({2'b0, 16'({8'b0, cfg.radius} * {8'b0, cfg.radius})});
		dsq    = dy_s2 * dy_s2;
		d2     = rsq - dsq;
		prod_r = cfg.right_dy * dy_s2;
		prod_l = cfg.left_dy * dy_s2;
	end

	always_comb begin
		cext  = {{10{cfg.near_ofs[31]}}, cfg.near_ofs};
		rhs_r = cext - {pr_s3[40], pr_s3};
		rhs_l = -cext - {pl_s3[40], pl_s3};
		skip3 = skip_s3 || (d2_s3 <= 0)
			|| ((cfg.right_dx == 0) && (rhs_r < 0))
			|| ((cfg.left_dx == 0) && (rhs_l > 0));
	end

	always_comb begin
		mag_r       = rhr_s4[41] ? 42'(-rhr_s4) : rhr_s4;
		mag_l       = rhl_s4[41] ? 42'(-rhl_s4) : rhl_s4;
		init        = '0;
		init.vld    = vld_s4;
		init.skip   = skip_s4;
		init.d2     = d2_s4;
		init.dr.neg = rhr_s4[41] ^ cfg.right_dx[31];
		init.dr.ovf = {1'b0, mag_r[41:11]} >= cfg.abs_right_dx;
		init.dr.rem = {2'b0, mag_r[41:11]};
		init.dr.low = mag_r[10:0];
		init.dl.neg = rhl_s4[41] ^ cfg.left_dx[31];
		init.dl.ovf = {1'b0, mag_l[41:11]} >= cfg.abs_left_dx;
		init.dl.rem = {2'b0, mag_l[41:11]};
		init.dl.low = mag_l[10:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			it_s5  <= '0;
		end else if (adv) begin
			vld_s1 <= req_xfer;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			it_s5  <= init;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s1  <= row_index;
			skip_s2 <= !reach;
			dy_s2   <= dy14[8:0];
			skip_s3 <= skip_s2;
			d2_s3   <= d2;
			pr_s3   <= prod_r;
			pl_s3   <= prod_l;
			skip_s4 <= skip3;
			d2_s4   <= d2_s3[15:0];
			rhr_s4  <= rhs_r;
			rhl_s4  <= rhs_l;
		end
	end

endmodule
`default_nettype wire

@@ design/rsfc_iter.sv @@
// One pipeline stage: one quotient bit of each plane divide, and one root bit while STEP < SQRT_STEPS.
// Depends on rsfc_pkg.
`default_nettype none
module rsfc_iter #(
	parameter int STEP = 0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire rsfc_pkg::rsfc_cfg_t cfg,
	input  wire rsfc_pkg::rsfc_iter_t it_in,
	output rsfc_pkg::rsfc_iter_t     it_out
);
	import rsfc_pkg::*;

	logic       dbit;
	logic [1:0] sbits;
	rsfc_iter_t nxt;
	logic [32:0] sh_r, sh_l;
	logic [26:0] srem_sh;
	logic [25:0] trial;

	if (STEP <= 10) begin : g_dbit
		assign dbit = it_in.dr.low[10 - STEP];
	end else begin : g_dzero
		assign dbit = 1'b0;
	end

	logic dbit_l;
	if (STEP <= 10) begin : g_dbit_l
		assign dbit_l = it_in.dl.low[10 - STEP];
	end else begin : g_dzero_l
		assign dbit_l = 1'b0;
	end

	if (STEP <= 7) begin : g_sbits
		assign sbits = it_in.d2[15 - 2 * STEP -: 2];
	end else begin : g_szero
		assign sbits = 2'b00;
	end

	always_comb begin
		nxt  = it_in;
		sh_r = {it_in.dr.rem[31:0], dbit};
		if (sh_r >= {1'b0, cfg.abs_right_dx}) begin
			nxt.dr.rem = sh_r - {1'b0, cfg.abs_right_dx};
			nxt.dr.quo = {it_in.dr.quo[25:0], 1'b1};
		end else begin
			nxt.dr.rem = sh_r;
			nxt.dr.quo = {it_in.dr.quo[25:0], 1'b0};
		end
		sh_l = {it_in.dl.rem[31:0], dbit_l};
		if (sh_l >= {1'b0, cfg.abs_left_dx}) begin
			nxt.dl.rem = sh_l - {1'b0, cfg.abs_left_dx};
			nxt.dl.quo = {it_in.dl.quo[25:0], 1'b1};
		end else begin
			nxt.dl.rem = sh_l;
			nxt.dl.quo = {it_in.dl.quo[25:0], 1'b0};
		end
		srem_sh = {it_in.srem[24:0], sbits};
		trial   = {it_in.root, 2'b01};
		if (STEP < SQRT_STEPS) begin
			if (srem_sh >= {1'b0, trial}) begin
				nxt.srem = srem_sh - {1'b0, trial};
				nxt.root = {it_in.root[22:0], 1'b1};
			end else begin
				nxt.srem = srem_sh;
				nxt.root = {it_in.root[22:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_out <= '0;
		end else if (adv) begin
			it_out <= nxt;
		end
	end

endmodule
`default_nettype wire

@@ design/rsfc_back.sv @@
// Back stages: plane bounds, margin and radius clamp, rounding, map clamp.
// Depends on rsfc_pkg.
`default_nettype none
module rsfc_back #(
	parameter int MAP_SIZE = rsfc_pkg::MAP_SIZE_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire rsfc_pkg::rsfc_cfg_t cfg,
	input  wire rsfc_pkg::rsfc_iter_t it_in,
	output logic                     vld_q,
	output logic                     span_valid_q,
	output logic [9:0]               span_left_q,
	output logic [9:0]               span_right_q
);
	import rsfc_pkg::*;

	localparam logic signed [13:0] MAP_MAX = 14'(MAP_SIZE - 1);
	localparam logic signed [29:0] MARGIN  = 30'sd196608;
	localparam logic signed [29:0] CEIL_ADD = 30'sd65535;

	logic               vld_b1, skip_b1, vld_b2, skip_b2, vld_b3, skip_b3;
	logic signed [28:0] qr_b1, ql_b1, d_b1, lo_b2, hi_b2;
	logic signed [13:0] fl_b3, cl_b3;

	logic [27:0]        mag_r, mag_l;
	logic signed [28:0] qr, ql, lo, hi;
	logic signed [29:0] lo30, hi30, rq, hc;
	logic               empty3, empty4;
	logic signed [13:0] xl, xr;

	always_comb begin
		mag_r = it_in.dr.ovf ? 28'h8000000 : {1'b0, it_in.dr.quo};
		mag_l = it_in.dl.ovf ? 28'h8000000 : {1'b0, it_in.dl.quo};
		qr    = it_in.dr.neg ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
		ql    = it_in.dl.neg ? -$signed({1'b0, mag_l}) : $signed({1'b0, mag_l});
	end

	always_comb begin
		lo = -d_b1;
		hi = d_b1;
		if (cfg.right_dx > 0 && qr_b1 < hi) begin
			hi = qr_b1;
		end
		if (cfg.right_dx < 0 && qr_b1 > lo) begin
			lo = qr_b1;
		end
		if (cfg.left_dx > 0 && ql_b1 > lo) begin
			lo = ql_b1;
		end
		if (cfg.left_dx < 0 && ql_b1 < hi) begin
			hi = ql_b1;
		end
	end

	always_comb begin
		rq   = $signed({6'b0, cfg.radius, 16'b0});
		lo30 = {lo_b2[28], lo_b2} - MARGIN;
		hi30 = {hi_b2[28], hi_b2} + MARGIN;
		if (lo30 < -rq) begin
			lo30 = -rq;
		end
		if (hi30 > rq) begin
			hi30 = rq;
		end
		empty3 = lo30 > hi30;
		hc     = hi30 + CEIL_ADD;
	end

	always_comb begin
		xl = $signed({4'b0, cfg.center_col}) + fl_b3;
		xr = $signed({4'b0, cfg.center_col}) + cl_b3;
		if (xl < 0) begin
			xl = '0;
		end
		if (xr > MAP_MAX) begin
			xr = MAP_MAX;
		end
		empty4 = skip_b3 || (xl > xr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_b1 <= 1'b0;
			vld_b2 <= 1'b0;
			vld_b3 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (adv) begin
			vld_b1 <= it_in.vld;
			vld_b2 <= vld_b1;
			vld_b3 <= vld_b2;
			vld_q  <= vld_b3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			skip_b1      <= it_in.skip;
			qr_b1        <= qr;
			ql_b1        <= ql;
			d_b1         <= $signed({5'b0, it_in.root});
			skip_b2      <= skip_b1;
			lo_b2        <= lo;
			hi_b2        <= hi;
			skip_b3      <= skip_b2 || empty3;
			fl_b3        <= lo30[29:16];
			cl_b3        <= hc[29:16];
			span_valid_q <= !empty4;
			span_left_q  <= empty4 ? 10'd0 : xl[9:0];
			span_right_q <= empty4 ? 10'd0 : xr[9:0];
		end
	end

endmodule
`default_nettype wire

@@ design/row_span_frustum_clip_top.sv @@
// Row span unit: one map row in, one column span (or skip) out.
// One row is taken every cycle unless the result side stalls. Depth is set
// by the 27-stage restoring divider that runs both plane divides side by
// side (the 24-step square root shares those stages).
// A stall on the result side holds the whole pipeline.
// Depends on rsfc_pkg, rsfc_front, rsfc_iter, rsfc_back.
`default_nettype none
`include "row_span_frustum_clip_top_defines.svh"
module row_span_frustum_clip_top #(
	parameter int MAP_SIZE = rsfc_pkg::MAP_SIZE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [9:0]  row_index,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic             span_valid,
	output logic [9:0]       span_left,
	output logic [9:0]       span_right
);
	import rsfc_pkg::*;

	logic signed [31:0] right_dx_q, right_dy_q, left_dx_q, left_dy_q, near_ofs_q;
	logic [9:0]         center_col_q, center_row_q;
	logic [7:0]         radius_q;
	rsfc_cfg_t          cfg;
	logic               adv;
	rsfc_iter_t         chain [DIV_STEPS + 1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_dx_q   <= '0;
			right_dy_q   <= '0;
			left_dx_q    <= '0;
			left_dy_q    <= '0;
			near_ofs_q   <= '0;
			center_col_q <= '0;
			center_row_q <= '0;
			radius_q     <= '0;
		end else if (cfg_we) begin
			case (rsfc_reg_t'(cfg_idx))
				REG_RIGHT_DX: right_dx_q   <= cfg_wdata;
				REG_RIGHT_DY: right_dy_q   <= cfg_wdata;
				REG_LEFT_DX:  left_dx_q    <= cfg_wdata;
				REG_LEFT_DY:  left_dy_q    <= cfg_wdata;
				REG_NEAR_OFS: near_ofs_q   <= cfg_wdata;
				REG_CENTER_C: center_col_q <= cfg_wdata[9:0];
				REG_CENTER_R: center_row_q <= cfg_wdata[9:0];
				REG_RADIUS:   radius_q     <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.right_dx     = right_dx_q;
		cfg.right_dy     = right_dy_q;
		cfg.left_dx      = left_dx_q;
		cfg.left_dy      = left_dy_q;
		cfg.near_ofs     = near_ofs_q;
		cfg.center_col   = center_col_q;
		cfg.center_row   = center_row_q;
		cfg.radius       = radius_q;
		cfg.abs_right_dx = right_dx_q[31] ? 32'(-right_dx_q) : right_dx_q;
		cfg.abs_left_dx  = left_dx_q[31] ? 32'(-left_dx_q) : left_dx_q;
	end

	assign adv       = !rsp_valid || rsp_ready;
	assign req_ready = adv;

	rsfc_front #(.MAP_SIZE(MAP_SIZE)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.req_xfer  (req_valid && adv),
		.row_index (row_index),
		.cfg       (cfg),
		.it_s5     (chain[0])
	);

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_iter
		rsfc_iter #(.STEP(g)) u_iter (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.cfg    (cfg),
			.it_in  (chain[g]),
			.it_out (chain[g + 1])
		);
	end

	rsfc_back #(.MAP_SIZE(MAP_SIZE)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.cfg          (cfg),
		.it_in        (chain[DIV_STEPS]),
		.vld_q        (rsp_valid),
		.span_valid_q (span_valid),
		.span_left_q  (span_left),
		.span_right_q (span_right)
	);

	`RSFC_CHECK_IMP(a_skip_zero, rsp_valid && !span_valid, span_left == 10'd0 && span_right == 10'd0, "skipped row carries nonzero columns")
	`RSFC_CHECK_IMP(a_span_order, rsp_valid && span_valid, (MAP_SIZE > 1024) || (span_left <= span_right), "span left end past right end")

endmodule
`default_nettype wire
